/* rtl/core/pcj_pkg.sv */
package pcj_pkg;

    // Result codes as seen on result_kind
    typedef enum logic [1:0] {
        KIND_POINT  = 2'd0,
        KIND_OK     = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    // One assembled point: x, y, z and intensity float32 words, x lowest
    localparam int POINT_W = 128;

    // What one input byte leaves for the back end: an optional reject of an
    // abandoned frame, an optional point, and an optional closing status.
    // At most two of them are ever set at once, and the second is the tail.
    typedef struct packed {
        logic                 lead_reject;
        logic                 point_valid;
        logic                 tail_valid;
        kind_t                tail_kind;
        logic [POINT_W-1:0]   point;
    } entry_t;

endpackage

/* rtl/core/pcj_front.sv */
module pcj_front #(
    parameter int LENGTH_BITS = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic [19:0]      frame_length,
    input  logic             full,
    output logic             push,
    output pcj_pkg::entry_t  entry
);
    import pcj_pkg::*;

    localparam int HEADER_BYTES = 12;
    localparam int COUNT_FIRST  = 8;
    localparam int POS_LAST     = 15;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_POINTS = 3'b100
    } phase_t;

    phase_t                   phase_reg, phase_next, cur_phase;
    logic [3:0]               pos_reg, pos_next, cur_pos;
    logic [LENGTH_BITS-1:0]   length_reg, length_next, cur_len, len_sel, body_len;
    logic [31:0]              count_reg, count_next, cur_count, len_wide;
    logic [POINT_W-1:0]       bytes_reg, bytes_next;
    logic                     accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign len_wide = 32'(frame_length);
    assign len_sel  = len_wide[LENGTH_BITS-1:0];
    assign body_len = cur_len - LENGTH_BITS'(HEADER_BYTES);

    // Frame walk: header count, then 16-byte points
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        length_next = length_reg;
        count_next  = count_reg;
        bytes_next  = bytes_reg;
        cur_phase   = phase_reg;
        cur_pos     = pos_reg;
        cur_count   = count_reg;
        cur_len     = length_reg;
        entry       = '0;
        entry.tail_kind = KIND_OK;

        if (accept)
        begin
            if (first_byte)
            begin
                // a frame still open is closed as rejected
                entry.lead_reject = (phase_reg != PH_IDLE);
                length_next = len_sel;
                cur_len     = len_sel;
                cur_pos     = '0;
                cur_count   = '0;
                pos_next    = '0;
                count_next  = '0;
                if (len_sel < LENGTH_BITS'(HEADER_BYTES))
                begin
                    cur_phase        = PH_IDLE;
                    phase_next       = PH_IDLE;
                    entry.tail_valid = 1'b1;
                    entry.tail_kind  = KIND_REJECT;
                end
                else
                begin
                    cur_phase  = PH_HEADER;
                    phase_next = PH_HEADER;
                end
            end

            case (cur_phase)
                PH_HEADER:
                begin
                    pos_next = cur_pos + 4'd1;
                    if (cur_pos >= 4'(COUNT_FIRST))
                        count_next = cur_count | (32'(data_byte) << {cur_pos[1:0], 3'b000});
                    if (cur_pos == 4'(HEADER_BYTES - 1))
                    begin
                        pos_next = '0;
                        // count*16 > length-12  <=>  count > (length-12)/16
                        if (count_next > 32'(body_len >> 4))
                        begin
                            phase_next       = PH_IDLE;
                            entry.tail_valid = 1'b1;
                            entry.tail_kind  = KIND_REJECT;
                        end
                        else if (count_next == 32'd0)
                        begin
                            phase_next       = PH_IDLE;
                            entry.tail_valid = 1'b1;
                            entry.tail_kind  = KIND_OK;
                        end
                        else
                        begin
                            phase_next = PH_POINTS;
                        end
                    end
                end
                PH_POINTS:
                begin
                    // little endian: shift in from the top, byte 0 ends lowest
                    bytes_next = {data_byte, bytes_reg[POINT_W-1:8]};
                    pos_next   = cur_pos + 4'd1;
                    if (cur_pos == 4'(POS_LAST))
                    begin
                        count_next  = cur_count - 32'd1;
                        entry.point = bytes_next;
                        // drop Inf/NaN coordinates
                        entry.point_valid = (bytes_next[30:23] != 8'hFF)
                                         && (bytes_next[62:55] != 8'hFF)
                                         && (bytes_next[94:87] != 8'hFF);
                        if (cur_count == 32'd1)
                        begin
                            phase_next       = PH_IDLE;
                            entry.tail_valid = 1'b1;
                            entry.tail_kind  = KIND_OK;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign push = accept && (entry.lead_reject || entry.point_valid || entry.tail_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            bytes_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            bytes_reg  <= bytes_next;
        end
    end

    a_points_have_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_POINTS |-> count_reg != 32'd0)
        else $error("points phase with zero points left");

    a_header_pos: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> pos_reg < 4'(HEADER_BYTES))
        else $error("header position past count field");

    a_abandon_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first_byte && phase_reg != PH_IDLE) |-> (push && entry.lead_reject))
        else $error("abandoned frame not rejected");

endmodule

/* rtl/core/pcj_queue.sv */
module pcj_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pcj_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output pcj_pkg::entry_t  head_entry
);
    import pcj_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* rtl/core/pcj_back.sv */
module pcj_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  pcj_pkg::entry_t  head_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       result_kind,
    output logic [31:0]      x_bits,
    output logic [31:0]      y_bits,
    output logic [31:0]      z_bits,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue
);
    import pcj_pkg::*;

    // 8.16 fixed point: 255.0 and the jet break points
    localparam logic [23:0] FIX_MAX    = 24'd16711680;
    localparam logic [23:0] BRK1       = 24'd4177920;
    localparam logic [23:0] BRK2       = 24'd8355840;
    localparam logic [23:0] BRK3       = 24'd12533760;
    localparam logic [30:0] BLUE_SCALE = 31'd508;

    logic          second_reg, second_next;
    logic          two_results, issue;
    logic          out_load, s2_open, s2_move, s1_open, s1_move;

    // issue stage
    kind_t         iss_kind;
    logic          iss_point;
    logic [95:0]   iss_xyz;
    logic [31:0]   ib;
    logic [7:0]    ib_exp, shamt;
    logic [23:0]   mant, fx_next;
    logic          nan_next;

    // stage 1: fixed point intensity
    logic          s1_valid_reg, s1_point_reg, s1_nan_reg;
    kind_t         s1_kind_reg;
    logic [95:0]   s1_xyz_reg;
    logic [23:0]   s1_fx_reg;

    // stage 2: segment and offset
    logic          s2_valid_reg, s2_point_reg, s2_nan_reg;
    kind_t         s2_kind_reg;
    logic [95:0]   s2_xyz_reg;
    logic [1:0]    s2_seg_reg, seg_next;
    logic [21:0]   s2_d_reg, d_next;

    // colour
    logic [30:0]   blue_prod;
    logic [14:0]   blue_q;
    logic [16:0]   blue_div;
    logic [24:0]   ceil_sum;
    logic [7:0]    floor4, ceil4;
    logic [7:0]    red_next, green_next, blue_next;

    // output register
    logic          out_valid_reg;
    kind_t         kind_reg;
    logic [95:0]   xyz_reg;
    logic [7:0]    red_reg, green_reg, blue_reg;

    // Stage enables
    assign out_load = !out_valid_reg || out_ready;
    assign s2_move  = s2_valid_reg && out_load;
    assign s2_open  = !s2_valid_reg || out_load;
    assign s1_move  = s1_valid_reg && s2_open;
    assign s1_open  = !s1_valid_reg || s2_open;
    assign issue    = head_valid && s1_open;

    // Unpack a queue entry into one or two results; the second is the tail
    assign two_results = (head_entry.lead_reject || head_entry.point_valid)
                      && head_entry.tail_valid;
    assign pop         = issue && (second_reg || !two_results);
    assign second_next = issue ? (!second_reg && two_results) : second_reg;

    always_comb
    begin
        if (second_reg)
        begin
            iss_kind  = head_entry.tail_kind;
            iss_point = 1'b0;
        end
        else if (head_entry.lead_reject)
        begin
            iss_kind  = KIND_REJECT;
            iss_point = 1'b0;
        end
        else if (head_entry.point_valid)
        begin
            iss_kind  = KIND_POINT;
            iss_point = 1'b1;
        end
        else
        begin
            iss_kind  = head_entry.tail_kind;
            iss_point = 1'b0;
        end
    end

    assign iss_xyz = iss_point ? head_entry.point[95:0] : 96'd0;

    // Intensity float32 to unsigned 8.16, truncating and clamped to 255.0
    assign ib       = head_entry.point[127:96];
    assign ib_exp   = ib[30:23];
    assign mant     = {1'b1, ib[22:0]};
    assign nan_next = (ib_exp == 8'hFF) && (ib[22:0] != 23'd0);
    assign shamt    = 8'd134 - ib_exp;

    always_comb
    begin
        if (ib[31] || ib_exp == 8'd0)
            fx_next = '0;
        else if (ib_exp >= 8'd135)
            fx_next = FIX_MAX;
        else if (shamt >= 8'd24)
            fx_next = '0;
        else
            fx_next = mant >> shamt[4:0];
        if (fx_next > FIX_MAX)
            fx_next = FIX_MAX;
    end

    // Segment select and offset from segment base
    always_comb
    begin
        if (s1_fx_reg < BRK1)
        begin
            seg_next = 2'd0;
            d_next   = 22'(s1_fx_reg);
        end
        else if (s1_fx_reg < BRK2)
        begin
            seg_next = 2'd1;
            d_next   = 22'(s1_fx_reg - BRK1);
        end
        else if (s1_fx_reg < BRK3)
        begin
            seg_next = 2'd2;
            d_next   = 22'(s1_fx_reg - BRK2);
        end
        else
        begin
            seg_next = 2'd3;
            d_next   = 22'(s1_fx_reg - BRK3);
        end
    end

    // Jet colour; blue ramp is floor(d*508/2^16) / 255 by reciprocal add
    assign blue_prod = 31'(s2_d_reg) * BLUE_SCALE;
    assign blue_q    = blue_prod[30:16];
    assign blue_div  = (17'(blue_q) + 17'd1 + 17'(blue_q >> 8)) >> 8;
    assign ceil_sum  = 25'({s2_d_reg, 2'b00}) + 25'd65535;
    assign ceil4     = ceil_sum[23:16];
    assign floor4    = s2_d_reg[21:14];

    always_comb
    begin
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        if (s2_point_reg)
        begin
            if (s2_nan_reg)
            begin
                red_next = 8'd255;
            end
            else
            begin
                case (s2_seg_reg)
                    2'd0:
                    begin
                        green_next = floor4;
                        blue_next  = 8'd128 + blue_div[7:0];
                    end
                    2'd1:
                    begin
                        green_next = 8'd255;
                        blue_next  = 8'd255 - ceil4;
                    end
                    2'd2:
                    begin
                        red_next   = floor4;
                        green_next = 8'd255;
                    end
                    default:
                    begin
                        red_next   = 8'd255;
                        green_next = 8'd255 - ceil4;
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            second_reg <= second_next;
            if (s1_open)
                s1_valid_reg <= issue;
            if (s2_open)
                s2_valid_reg <= s1_valid_reg;
            if (out_load)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_kind_reg  <= iss_kind;
            s1_point_reg <= iss_point;
            s1_xyz_reg   <= iss_xyz;
            s1_nan_reg   <= nan_next;
            s1_fx_reg    <= fx_next;
        end
        if (s1_move)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_point_reg <= s1_point_reg;
            s2_xyz_reg   <= s1_xyz_reg;
            s2_nan_reg   <= s1_nan_reg;
            s2_seg_reg   <= seg_next;
            s2_d_reg     <= d_next;
        end
        if (s2_move)
        begin
            kind_reg  <= s2_kind_reg;
            xyz_reg   <= s2_xyz_reg;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign x_bits      = xyz_reg[31:0];
    assign y_bits      = xyz_reg[63:32];
    assign z_bits      = xyz_reg[95:64];
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_POINT) |->
            (red_reg == 8'd0 && green_reg == 8'd0 && blue_reg == 8'd0 && xyz_reg == 96'd0))
        else $error("status beat carries point data");

    a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> head_valid)
        else $error("second result pending with empty queue");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_open) |=> (s1_valid_reg && $stable(s1_kind_reg)
                                        && $stable(s1_fx_reg)))
        else $error("stage 1 lost its beat under stall");

endmodule

/* rtl/core/point_cloud_parser_jet_colour.sv */
// Point-cloud frame parser with jet colouring. Bytes of a little-endian frame enter one
// per cycle on in_valid/in_ready, first_byte marking the start of a frame and frame_length
// sampled with it. Results leave on out_valid/out_ready: one beat per finite point (raw
// x/y/z bits plus jet colour from the intensity) and one status beat closing each frame
// (kind 1 ok, kind 2 rejected; all other fields zero). The front end takes one byte every
// cycle while its four-entry event queue has room; the back end drains one result per
// cycle unless out_ready stalls it, through a three-register pipeline (fixed-point
// conversion, segment select, colour), so a byte's first result is presented only after
// the queue slot and all three registers. A byte that yields two results (the last point
// with its finish beat, or an abandoned frame followed by a short one) is issued to the
// back end as two results in turn, the tail second, which the queue absorbs.
module point_cloud_parser_jet_colour #(
    parameter int LENGTH_BITS = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         first_byte,
    input  logic [19:0]  frame_length,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   result_kind,
    output logic [31:0]  x_bits,
    output logic [31:0]  y_bits,
    output logic [31:0]  z_bits,
    output logic [7:0]   red,
    output logic [7:0]   green,
    output logic [7:0]   blue
);
    import pcj_pkg::*;

    logic    q_full, q_push, q_pop, q_head_valid;
    entry_t  q_push_entry, q_head_entry;

    pcj_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .frame_length (frame_length),
        .full         (q_full),
        .push         (q_push),
        .entry        (q_push_entry)
    );

    pcj_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    pcj_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_entry  (q_head_entry),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .x_bits      (x_bits),
        .y_bits      (y_bits),
        .z_bits      (z_bits),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

endmodule
